### hw/rtl/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types for the Kruskal spanning tree core: edge words, result words
// and the sequencer states.
// ----------------------------------------------------------------------------
package kmst_pkg;

  typedef struct packed {
    logic [4:0]         from_node;
    logic [4:0]         to_node;
    logic signed [15:0] weight;
    logic               last_edge;
  } kmst_in_t;

  typedef struct packed {
    logic [4:0]         out_from;
    logic [4:0]         out_to;
    logic signed [15:0] out_weight;
    logic               last_result;
    logic               none_found;
    logic               overflow;
  } kmst_out_t;

  // one stored edge word
  typedef struct packed {
    logic [4:0]         from_node;
    logic [4:0]         to_node;
    logic signed [15:0] weight;
  } kmst_edge_t;

  localparam int EDGE_W = $bits(kmst_edge_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT,
    ST_SRT_RI,
    ST_SRT_SCAN,
    ST_SRT_WI,
    ST_SRT_WM,
    ST_INIT,
    ST_K_RD,
    ST_K_CAP,
    ST_WALK,
    ST_SZ1,
    ST_SZ2,
    ST_SZ3,
    ST_DONE
  } kmst_state_t;

endpackage

### hw/rtl/kmst_ram.sv
// ----------------------------------------------------------------------------
// kmst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/kruskal_mst_union_find_core.sv
// ----------------------------------------------------------------------------
// kruskal_mst_union_find_core
// Loads weighted edges, then selection-sorts them and runs Kruskal with
// union-find by size, emitting the spanning tree edges in weight order.
// ----------------------------------------------------------------------------
// Usage: present an edge word on in_edge with start high while busy is low;
// it is taken at that clock edge. Loading takes one edge per cycle and busy
// stays low. The word with last_edge set starts the run and busy stays high
// until the cycle in which the final result is on the ports. Edges beyond
// MAX_EDGES are dropped and the overflow bit of every result of that run is set.
// Results appear on out_result for one cycle each, marked by out_valid; the
// receiver cannot stall them. The final one carries last_result; a run with
// no accepted edge gives one word with none_found set and zero edge fields.
// A run counts the nodes over the stored edges, selection-sorts the edges,
// sweeps all MAX_NODES union-find entries to init them, then examines the
// edges in order: two root walks per edge, and for an accepted one a size
// read and merge. All steps share one edge RAM read port and the parent and
// size RAMs. Synchronous reset clears the control state; the union-find
// RAMs are not reset but are swept by the init step of each run.
// ----------------------------------------------------------------------------
module kruskal_mst_union_find_core
  import kmst_pkg::*;
#(
  parameter int MAX_EDGES = 64,
  parameter int MAX_NODES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  kmst_in_t  in_edge,
  output logic      out_valid,
  output kmst_out_t out_result
);

  localparam int AW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int NW = $clog2(MAX_NODES);
  localparam int SW = $clog2(MAX_NODES + 1);

  // node id reduction table
  logic [NW-1:0] mod_tab [32];
  for (genvar g = 0; g < 32; g++) begin : g_mod
    assign mod_tab[g] = NW'(g % MAX_NODES);
  end

  kmst_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic          drop_r, drop_nxt, dv_r, dv_nxt, first_r, first_nxt;
  logic [AW-1:0] didx_r, didx_nxt, m_r, m_nxt;
  kmst_edge_t    min_r, min_nxt, old_r, old_nxt, e_r, e_nxt;
  logic [MAX_NODES-1:0] seen_r, seen_nxt;
  logic [SW-1:0] nodes_r, nodes_nxt, acc_r, acc_nxt, sz1_r, sz1_nxt;
  logic [NW-1:0] k_r, k_nxt, wn_r, wn_nxt, r1_r, r1_nxt;
  logic          phase_r, phase_nxt, pend_v_r, pend_v_nxt, outv_r, outv_nxt;
  kmst_out_t     pend_r, pend_nxt, out_r, out_nxt;

  logic            e_we;
  logic [AW-1:0]   e_waddr, e_raddr;
  kmst_edge_t      e_wdata, e_rdata;
  logic            p_we, s_we;
  logic [NW-1:0]   p_waddr, p_wdata, p_raddr, p_rdata, s_waddr, s_raddr;
  logic [SW-1:0]   s_wdata, s_rdata;

  kmst_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  kmst_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  kmst_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_size_ram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = outv_r;
  assign out_result = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      drop_r   <= 1'b0;
      dv_r     <= 1'b0;
      pend_v_r <= 1'b0;
      outv_r   <= 1'b0;
      seen_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      drop_r   <= drop_nxt;
      dv_r     <= dv_nxt;
      pend_v_r <= pend_v_nxt;
      outv_r   <= outv_nxt;
      seen_r   <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    first_r <= first_nxt;
    didx_r  <= didx_nxt;
    m_r     <= m_nxt;
    min_r   <= min_nxt;
    old_r   <= old_nxt;
    e_r     <= e_nxt;
    nodes_r <= nodes_nxt;
    acc_r   <= acc_nxt;
    sz1_r   <= sz1_nxt;
    k_r     <= k_nxt;
    wn_r    <= wn_nxt;
    r1_r    <= r1_nxt;
    phase_r <= phase_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  logic [NW-1:0] fm, tm;
  logic          f_new, t_new;
  kmst_edge_t    in_word;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    drop_nxt   = drop_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    dv_nxt     = 1'b0;
    first_nxt  = first_r;
    didx_nxt   = didx_r;
    m_nxt      = m_r;
    min_nxt    = min_r;
    old_nxt    = old_r;
    e_nxt      = e_r;
    seen_nxt   = seen_r;
    nodes_nxt  = nodes_r;
    acc_nxt    = acc_r;
    sz1_nxt    = sz1_r;
    k_nxt      = k_r;
    wn_nxt     = wn_r;
    r1_nxt     = r1_r;
    phase_nxt  = phase_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    outv_nxt   = 1'b0;
    out_nxt    = out_r;

    e_we    = 1'b0;
    e_waddr = cnt_r[AW-1:0];
    in_word = '{from_node: in_edge.from_node, to_node: in_edge.to_node,
                weight: in_edge.weight};
    e_wdata = in_word;
    e_raddr = i_r[AW-1:0];
    p_we    = 1'b0;
    p_waddr = k_r;
    p_wdata = k_r;
    p_raddr = wn_r;
    s_we    = 1'b0;
    s_waddr = k_r;
    s_wdata = SW'(1);
    s_raddr = r1_r;

    fm    = mod_tab[e_rdata.from_node];
    tm    = mod_tab[e_rdata.to_node];
    f_new = !seen_r[fm];
    t_new = !seen_r[tm] && (tm != fm);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (cnt_r < CW'(MAX_EDGES)) begin
            e_we    = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_edge.last_edge) begin
            i_nxt     = '0;
            seen_nxt  = '0;
            nodes_nxt = '0;
            state_nxt = ST_CNT;
          end
        end
      end
      ST_CNT: begin
        if (i_r < cnt_r) begin
          e_raddr = i_r[AW-1:0];
          dv_nxt  = 1'b1;
          i_nxt   = i_r + CW'(1);
        end
        if (dv_r) begin
          seen_nxt[fm] = 1'b1;
          seen_nxt[tm] = 1'b1;
          nodes_nxt    = nodes_r + SW'(f_new) + SW'(t_new);
        end else if (!(i_r < cnt_r)) begin
          i_nxt     = '0;
          state_nxt = ST_SRT_RI;
        end
      end
      ST_SRT_RI: begin
        if (i_r < cnt_r) begin
          e_raddr   = i_r[AW-1:0];
          dv_nxt    = 1'b1;
          didx_nxt  = i_r[AW-1:0];
          first_nxt = 1'b1;
          j_nxt     = i_r + CW'(1);
          state_nxt = ST_SRT_SCAN;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_INIT;
        end
      end
      ST_SRT_SCAN: begin
        if (j_r < cnt_r) begin
          e_raddr  = j_r[AW-1:0];
          dv_nxt   = 1'b1;
          didx_nxt = j_r[AW-1:0];
          j_nxt    = j_r + CW'(1);
        end
        if (dv_r) begin
          if (first_r) begin
            min_nxt   = e_rdata;
            old_nxt   = e_rdata;
            m_nxt     = didx_r;
            first_nxt = 1'b0;
          end else if ($signed(e_rdata.weight) < $signed(min_r.weight)) begin
            min_nxt = e_rdata;
            m_nxt   = didx_r;
          end
        end else begin
          state_nxt = ST_SRT_WI;
        end
      end
      ST_SRT_WI: begin
        e_we      = 1'b1;
        e_waddr   = i_r[AW-1:0];
        e_wdata   = min_r;
        state_nxt = ST_SRT_WM;
      end
      ST_SRT_WM: begin
        e_we      = 1'b1;
        e_waddr   = m_r;
        e_wdata   = old_r;
        i_nxt     = i_r + CW'(1);
        state_nxt = ST_SRT_RI;
      end
      ST_INIT: begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        k_nxt   = k_r + NW'(1);
        if (k_r == NW'(MAX_NODES - 1)) begin
          i_nxt      = '0;
          acc_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_K_RD;
        end
      end
      ST_K_RD: begin
        if ((i_r < cnt_r) && ({1'b0, acc_r} + (SW + 1)'(1) < {1'b0, nodes_r})) begin
          e_raddr   = i_r[AW-1:0];
          state_nxt = ST_K_CAP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_K_CAP: begin
        e_nxt     = e_rdata;
        wn_nxt    = fm;
        p_raddr   = fm;
        phase_nxt = 1'b0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (p_rdata != wn_r) begin
          // climb one level
          wn_nxt  = p_rdata;
          p_raddr = p_rdata;
        end else if (!phase_r) begin
          r1_nxt    = wn_r;
          wn_nxt    = mod_tab[e_r.to_node];
          p_raddr   = mod_tab[e_r.to_node];
          phase_nxt = 1'b1;
        end else if (wn_r == r1_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_K_RD;
        end else begin
          state_nxt = ST_SZ1;
        end
      end
      ST_SZ1: begin
        s_raddr   = r1_r;
        state_nxt = ST_SZ2;
      end
      ST_SZ2: begin
        s_raddr   = wn_r;
        state_nxt = ST_SZ3;
      end
      ST_SZ3: begin
        state_nxt = ST_K_RD;
        // sizes: r1 captured last cycle in sz1_r, r2 on the read port now
        p_we    = 1'b1;
        s_we    = 1'b1;
        s_wdata = sz1_r + s_rdata;
        if (sz1_r >= s_rdata) begin
          p_waddr = wn_r;
          p_wdata = r1_r;
          s_waddr = r1_r;
        end else begin
          p_waddr = r1_r;
          p_wdata = wn_r;
          s_waddr = wn_r;
        end
        if (pend_v_r) begin
          outv_nxt = 1'b1;
          out_nxt  = pend_r;
        end
        pend_v_nxt = 1'b1;
        pend_nxt   = '{out_from: e_r.from_node, out_to: e_r.to_node,
                       out_weight: e_r.weight, last_result: 1'b0,
                       none_found: 1'b0, overflow: drop_r};
        acc_nxt    = acc_r + SW'(1);
        i_nxt      = i_r + CW'(1);
      end
      ST_DONE: begin
        outv_nxt = 1'b1;
        if (pend_v_r) begin
          out_nxt             = pend_r;
          out_nxt.last_result = 1'b1;
        end else begin
          out_nxt = '{out_from: '0, out_to: '0, out_weight: '0,
                      last_result: 1'b1, none_found: 1'b1, overflow: drop_r};
        end
        pend_v_nxt = 1'b0;
        cnt_nxt    = '0;
        drop_nxt   = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // capture size of r1 as it comes off the read port
    if (state_r == ST_SZ2) begin
      sz1_nxt = s_rdata;
    end
  end

  // a run always ends with exactly one final word, on the ports in the cycle busy drops
  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_result.last_result))
    else $error("run ended without final result word");

  // no new input while computing, so a final word never overlaps a run
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.last_result) |-> !busy)
    else $error("final result while still busy");

  // accepted edges never reach the node count
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K_CAP) |-> (acc_r < nodes_r))
    else $error("edge examined after tree complete");

  // the edge count never exceeds capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_EDGES))
    else $error("edge count beyond capacity");

endmodule
